// File: src/wpm_pkg.sv
// Shared types, constants and the log2 squaring step for the windowed power meter.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package wpm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int IQ_W        = 2 * SAMPLE_BITS;
    localparam int PW_W        = 2 * SAMPLE_BITS;
    localparam int MANT_W      = 32;
    localparam int FRAC_BITS   = 16;
    localparam int LEVEL_W     = 17;
    localparam int WLEN_W      = 13;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int ROUND_SHIFT = 24;

    localparam int OUT_FIFO_DEPTH = 32;
    localparam int OUT_PTR_W      = $clog2(OUT_FIFO_DEPTH);
    localparam int OUT_CNT_W      = $clog2(OUT_FIFO_DEPTH + 1);

    localparam logic [WLEN_W-1:0]         WINDOW_LEN_RESET = 13'd4096;
    localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR_Q8   = -17'sd51200;
    localparam logic signed [LEVEL_W-1:0] LEVEL_CEIL_Q8    = 17'sd65535;
    localparam logic signed [18:0]        DB_PER_LOG2_Q16  = 19'sd197283;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic REG_WINDOW_LEN = 1'b0;

    typedef struct packed {
        logic                           command;
        logic signed [SAMPLE_BITS-1:0]  sample_i;
        logic signed [SAMPLE_BITS-1:0]  sample_q;
    } in_word_t;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level_db_q8;
        logic                      no_data;
    } out_word_t;

    typedef struct packed {
        logic valid;
        logic no_data;
        logic zero;
    } level_ctl_t;

    // one mantissa squaring step: {fraction bit, next mantissa}
    function automatic logic [MANT_W:0] sq_step(input logic [MANT_W-1:0] m);
        logic [2*MANT_W-1:0] p;
        logic [MANT_W:0]     t;
        p = {{MANT_W{1'b0}}, m} * {{MANT_W{1'b0}}, m};
        t = p[2*MANT_W-1:MANT_W-1];
        if (t[MANT_W])
        begin
            return {1'b1, t[MANT_W:1]};
        end
        return {1'b0, t[MANT_W-1:0]};
    endfunction

endpackage

// File: src/wpm_len_log.sv
// Iterative log2 of the effective window length in Q16, one squaring step per cycle.
// Depends on wpm_pkg (sq_step, MANT_W, FRAC_BITS).
`timescale 1ns / 1ps

module wpm_len_log #(
    parameter int LEN_W = 13,
    parameter int LOG_W = 22
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [LEN_W-1:0] len,
    output logic             busy,
    output logic [LOG_W-1:0] log_len
);

    localparam int LE_W  = $clog2(LEN_W);
    localparam int CNT_W = $clog2(wpm_pkg::FRAC_BITS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_SQR  = 2'd2;

    logic [1:0]                       state_reg, state_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic [LE_W-1:0]                  e_reg, e_next;
    logic [wpm_pkg::MANT_W-1:0]       m_reg, m_next;
    logic [wpm_pkg::FRAC_BITS-1:0]    frac_reg, frac_next;
    logic [LE_W-1:0]                  lead;
    logic [LEN_W+wpm_pkg::MANT_W-2:0] wide;
    logic [wpm_pkg::MANT_W:0]         step;

    always_comb
    begin
        lead = '0;
        for (int k = 0; k < LEN_W; k++)
        begin
            if (len[k])
            begin
                lead = LE_W'(k);
            end
        end
    end

    assign wide = {len, {(wpm_pkg::MANT_W-1){1'b0}}} >> lead;
    assign step = wpm_pkg::sq_step(m_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        e_next     = e_reg;
        m_next     = m_reg;
        frac_next  = frac_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                e_next     = lead;
                m_next     = wide[wpm_pkg::MANT_W-1:0];
                frac_next  = '0;
                cnt_next   = '0;
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                m_next    = step[wpm_pkg::MANT_W-1:0];
                frac_next = {frac_reg[wpm_pkg::FRAC_BITS-2:0], step[wpm_pkg::MANT_W]};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(wpm_pkg::FRAC_BITS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (start)
        begin
            state_next = ST_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg    <= e_next;
        m_reg    <= m_next;
        frac_reg <= frac_next;
    end

    assign busy    = (state_reg != ST_IDLE);
    assign log_len = LOG_W'({e_reg, frac_reg});

endmodule

// File: src/wpm_level_pipe.sv
// Pipelined dB conversion of the window sum: leading one, normalize, 16 squaring
// stages, scale by 10*log10(2), round and limit. Depends on wpm_pkg.
`timescale 1ns / 1ps

module wpm_level_pipe #(
    parameter int SUM_W = 44,
    parameter int LOG_W = 22
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wpm_pkg::level_ctl_t in_ctl,
    input  logic [SUM_W-1:0]    sum,
    input  logic [LOG_W-1:0]    log_len,
    output logic                res_valid,
    output wpm_pkg::out_word_t  res_data
);

    localparam int E_W  = $clog2(SUM_W);
    localparam int FB   = wpm_pkg::FRAC_BITS;
    localparam int MW   = wpm_pkg::MANT_W;
    localparam int D_W  = LOG_W + 1;
    localparam int P_W  = D_W + 19;
    localparam int RM_W = P_W - wpm_pkg::ROUND_SHIFT;

    wpm_pkg::level_ctl_t ctl0_reg, ctl1_reg, ctld_reg, ctlr_reg;
    wpm_pkg::level_ctl_t ctl_reg [FB+1];

    logic [SUM_W-1:0]         x0_reg, x1_reg;
    logic [E_W-1:0]           e1_reg;
    logic [E_W-1:0]           e_reg    [FB+1];
    logic [MW-1:0]            m_reg    [FB+1];
    logic [FB-1:0]            frac_reg [FB+1];
    logic signed [P_W-1:0]    prod_reg;
    logic [wpm_pkg::LEVEL_W-1:0] level_reg;

    logic [E_W-1:0]           lead;
    logic [SUM_W+MW-2:0]      wide;
    logic signed [D_W-1:0]    d;
    logic signed [P_W-1:0]    prod_next;
    logic                     neg;
    logic [P_W-1:0]           mag;
    logic [P_W-1:0]           rnd;
    logic [RM_W-1:0]          rm;
    logic signed [wpm_pkg::LEVEL_W-1:0] level_next;

    always_comb
    begin
        lead = '0;
        for (int k = 0; k < SUM_W; k++)
        begin
            if (x0_reg[k])
            begin
                lead = E_W'(k);
            end
        end
    end

    assign wide = {x1_reg, {(MW-1){1'b0}}} >> e1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg   <= '0;
            ctl1_reg   <= '0;
            ctl_reg[0] <= '0;
        end
        else
        begin
            ctl0_reg         <= in_ctl;
            ctl1_reg         <= ctl0_reg;
            ctl_reg[0]       <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg      <= sum;
        x1_reg      <= x0_reg;
        e1_reg      <= lead;
        e_reg[0]    <= e1_reg;
        m_reg[0]    <= wide[MW-1:0];
        frac_reg[0] <= '0;
    end

    for (genvar k = 0; k < FB; k++)
    begin : g_sqr
        logic [MW:0] step;

        assign step = wpm_pkg::sq_step(m_reg[k]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k+1] <= '0;
            end
            else
            begin
                ctl_reg[k+1] <= ctl_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            e_reg[k+1]    <= e_reg[k];
            m_reg[k+1]    <= step[MW-1:0];
            frac_reg[k+1] <= {frac_reg[k][FB-2:0], step[MW]};
        end
    end

    assign d         = $signed({1'b0, LOG_W'({e_reg[FB], frac_reg[FB]})})
                     - $signed({1'b0, log_len});
    assign prod_next = P_W'(d) * P_W'(wpm_pkg::DB_PER_LOG2_Q16);

    assign neg = prod_reg[P_W-1];
    assign mag = neg ? P_W'(-prod_reg) : P_W'(prod_reg);
    assign rnd = mag + (P_W'(1) << (wpm_pkg::ROUND_SHIFT - 1));
    assign rm  = rnd[P_W-1:wpm_pkg::ROUND_SHIFT];

    always_comb
    begin
        if (ctld_reg.no_data || ctld_reg.zero)
        begin
            level_next = wpm_pkg::LEVEL_FLOOR_Q8;
        end
        else if (neg)
        begin
            if (rm > RM_W'(51200))
            begin
                level_next = wpm_pkg::LEVEL_FLOOR_Q8;
            end
            else
            begin
                level_next = wpm_pkg::LEVEL_W'(RM_W'(0) - rm);
            end
        end
        else if (rm > RM_W'(wpm_pkg::LEVEL_CEIL_Q8))
        begin
            level_next = wpm_pkg::LEVEL_CEIL_Q8;
        end
        else
        begin
            level_next = wpm_pkg::LEVEL_W'(rm);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctld_reg <= '0;
            ctlr_reg <= '0;
        end
        else
        begin
            ctld_reg <= ctl_reg[FB];
            ctlr_reg <= ctld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        level_reg <= level_next;
    end

    assign res_valid            = ctlr_reg.valid;
    assign res_data.level_db_q8 = $signed(level_reg);
    assign res_data.no_data     = ctlr_reg.no_data;

endmodule

// File: src/windowed_power_meter_db_unit.sv
// Windowed power meter: sample store, running window sum, dB read-out and result queue.
// Depends on wpm_pkg, wpm_len_log and wpm_level_pipe.
// Throughput: one word per cycle, pushes and reads alike; the 32-entry result queue
//   holds in_ready low while 32 read results are outstanding.
// Reset and window_len writes: in_ready stays low while the iterative log2 of
//   the window length runs; the sample store is not cleared, the fill count is.
`timescale 1ns / 1ps

module windowed_power_meter_db_unit #(
    parameter int WINDOW_MAX = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  wpm_pkg::in_word_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output wpm_pkg::out_word_t            out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wpm_pkg::PADDR_W-1:0]   paddr,
    input  logic [wpm_pkg::PDATA_W-1:0]   pwdata,
    output logic [wpm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int IDX_W = $clog2(WINDOW_MAX);
    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int AW    = LEN_W + 1;
    localparam int SUM_W = wpm_pkg::PW_W + IDX_W;
    localparam int LOG_W = $clog2(SUM_W) + wpm_pkg::FRAC_BITS;
    localparam int SB    = wpm_pkg::SAMPLE_BITS;
    localparam int PW_W  = wpm_pkg::PW_W;
    localparam int EFF_RESET = (WINDOW_MAX < 4096) ? WINDOW_MAX : 4096;

    logic [wpm_pkg::WLEN_W-1:0] window_len_reg;
    logic [LEN_W-1:0]           eff_len_reg, eff_len_next;
    logic [IDX_W-1:0]           wr_idx_reg;
    logic [LEN_W-1:0]           fill_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [wpm_pkg::OUT_CNT_W-1:0] cred_reg;

    logic [wpm_pkg::IQ_W-1:0]   store_mem [WINDOW_MAX];
    logic [wpm_pkg::IQ_W-1:0]   old_iq_reg;

    logic                       a_valid_reg, b_valid_reg, c_valid_reg;
    logic                       a_cmd_reg, b_cmd_reg, c_cmd_reg;
    logic                       a_drop_reg;
    logic                       a_nodata_reg, b_nodata_reg, c_nodata_reg;
    logic signed [SB-1:0]       a_i_reg, a_q_reg;
    logic [PW_W-1:0]            b_ii_reg, b_qq_reg, b_oi_reg, b_oq_reg;
    logic [PW_W-1:0]            c_new_reg, c_old_reg;

    wpm_pkg::out_word_t         fifo_mem [wpm_pkg::OUT_FIFO_DEPTH];
    logic [wpm_pkg::OUT_PTR_W-1:0] fifo_wr_reg, fifo_rd_reg;
    logic [wpm_pkg::OUT_CNT_W-1:0] fifo_cnt_reg;

    logic                       cfg_wr;
    logic                       in_acc, push_acc, read_acc, out_acc;
    logic                       full;
    logic [AW-1:0]              old_sub;
    logic [IDX_W-1:0]           old_idx;
    logic [wpm_pkg::WLEN_W-1:0] wv;
    logic                       len_busy;
    logic [LOG_W-1:0]           log_len;
    logic signed [SB-1:0]       old_i, old_q;
    wpm_pkg::level_ctl_t        pipe_ctl;
    logic                       res_valid;
    wpm_pkg::out_word_t         res_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == wpm_pkg::REG_WINDOW_LEN);
    assign prdata = (paddr[2] == wpm_pkg::REG_WINDOW_LEN)
                  ? wpm_pkg::PDATA_W'(window_len_reg) : '0;

    assign in_ready = !len_busy && (cred_reg != wpm_pkg::OUT_CNT_W'(wpm_pkg::OUT_FIFO_DEPTH));
    assign in_acc   = in_valid && in_ready;
    assign push_acc = in_acc && (in_data.command == wpm_pkg::CMD_PUSH);
    assign read_acc = in_acc && (in_data.command == wpm_pkg::CMD_READ);
    assign out_acc  = out_valid && out_ready;

    assign full    = (fill_reg >= eff_len_reg);
    assign old_sub = AW'(wr_idx_reg) - AW'(eff_len_reg);
    assign old_idx = old_sub[AW-1] ? IDX_W'(old_sub + AW'(WINDOW_MAX)) : IDX_W'(old_sub);

    assign wv = pwdata[wpm_pkg::WLEN_W-1:0];

    always_comb
    begin
        if (wv == '0)
        begin
            eff_len_next = LEN_W'(1);
        end
        else if (32'(wv) > 32'(WINDOW_MAX))
        begin
            eff_len_next = LEN_W'(WINDOW_MAX);
        end
        else
        begin
            eff_len_next = LEN_W'(wv);
        end
    end

    wpm_len_log #(
        .LEN_W (LEN_W),
        .LOG_W (LOG_W)
    ) u_len_log (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cfg_wr),
        .len     (eff_len_reg),
        .busy    (len_busy),
        .log_len (log_len)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= wpm_pkg::WINDOW_LEN_RESET;
            eff_len_reg    <= LEN_W'(EFF_RESET);
            wr_idx_reg     <= '0;
            fill_reg       <= '0;
            sum_reg        <= '0;
            cred_reg       <= '0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            fifo_wr_reg    <= '0;
            fifo_rd_reg    <= '0;
            fifo_cnt_reg   <= '0;
        end
        else
        begin
            a_valid_reg <= in_acc;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;

            if (push_acc)
            begin
                wr_idx_reg <= (wr_idx_reg == IDX_W'(WINDOW_MAX - 1)) ? '0 : wr_idx_reg + 1'b1;
            end

            if (cfg_wr)
            begin
                window_len_reg <= wv;
                eff_len_reg    <= eff_len_next;
                fill_reg       <= '0;
                sum_reg        <= '0;
            end
            else
            begin
                if (push_acc && !full)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                if (c_valid_reg && (c_cmd_reg == wpm_pkg::CMD_PUSH))
                begin
                    sum_reg <= sum_reg + SUM_W'(c_new_reg) - SUM_W'(c_old_reg);
                end
            end

            cred_reg <= cred_reg + wpm_pkg::OUT_CNT_W'(read_acc)
                      - wpm_pkg::OUT_CNT_W'(out_acc);

            if (res_valid)
            begin
                fifo_wr_reg <= fifo_wr_reg + 1'b1;
            end
            if (out_acc)
            begin
                fifo_rd_reg <= fifo_rd_reg + 1'b1;
            end
            fifo_cnt_reg <= fifo_cnt_reg + wpm_pkg::OUT_CNT_W'(res_valid)
                          - wpm_pkg::OUT_CNT_W'(out_acc);
        end
    end

    // sample store: read the leaving sample, write the new one
    always_ff @(posedge clk)
    begin
        if (push_acc)
        begin
            store_mem[wr_idx_reg] <= {in_data.sample_i, in_data.sample_q};
        end
        old_iq_reg <= store_mem[old_idx];
    end

    assign old_i = $signed(old_iq_reg[wpm_pkg::IQ_W-1:SB]);
    assign old_q = $signed(old_iq_reg[SB-1:0]);

    always_ff @(posedge clk)
    begin
        a_cmd_reg    <= in_data.command;
        a_drop_reg   <= full;
        a_nodata_reg <= !full;
        a_i_reg      <= in_data.sample_i;
        a_q_reg      <= in_data.sample_q;

        b_cmd_reg    <= a_cmd_reg;
        b_nodata_reg <= a_nodata_reg;
        b_ii_reg     <= PW_W'(PW_W'(a_i_reg) * PW_W'(a_i_reg));
        b_qq_reg     <= PW_W'(PW_W'(a_q_reg) * PW_W'(a_q_reg));
        b_oi_reg     <= a_drop_reg ? PW_W'(PW_W'(old_i) * PW_W'(old_i)) : '0;
        b_oq_reg     <= a_drop_reg ? PW_W'(PW_W'(old_q) * PW_W'(old_q)) : '0;

        c_cmd_reg    <= b_cmd_reg;
        c_nodata_reg <= b_nodata_reg;
        c_new_reg    <= b_ii_reg + b_qq_reg;
        c_old_reg    <= b_oi_reg + b_oq_reg;
    end

    assign pipe_ctl.valid   = c_valid_reg && (c_cmd_reg == wpm_pkg::CMD_READ);
    assign pipe_ctl.no_data = c_nodata_reg;
    assign pipe_ctl.zero    = (sum_reg == '0);

    wpm_level_pipe #(
        .SUM_W (SUM_W),
        .LOG_W (LOG_W)
    ) u_level_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (pipe_ctl),
        .sum       (sum_reg),
        .log_len   (log_len),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            fifo_mem[fifo_wr_reg] <= res_data;
        end
    end

    assign out_valid = (fifo_cnt_reg != '0);
    assign out_data  = fifo_mem[fifo_rd_reg];

endmodule

// File: src/wpm_checker.sv
// Port-level checks for the windowed power meter, bound to the top level.
// Depends on wpm_pkg and windowed_power_meter_db_unit.
`timescale 1ns / 1ps

module wpm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input wpm_pkg::out_word_t          out_data,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [wpm_pkg::PADDR_W-1:0] paddr
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[2] == wpm_pkg::REG_WINDOW_LEN) |=> !in_ready)
        else $error("input taken while window length log is recomputed");

    a_no_data_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.no_data |-> out_data.level_db_q8 == wpm_pkg::LEVEL_FLOOR_Q8)
        else $error("no_data result without floor level");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.level_db_q8 >= wpm_pkg::LEVEL_FLOOR_Q8)
        else $error("level below floor");

endmodule

bind windowed_power_meter_db_unit wpm_checker u_wpm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr)
);

// File: bench/testbench.sv
// Testbench for windowed_power_meter_db_unit: IQ pushes and level reads over valid/ready,
// window length writes over the APB port, each read result checked against a tracker.
// Depends on wpm_pkg and the windowed_power_meter_db_unit RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int STORE_DEPTH      = 4096;
    localparam int LEVEL_FLOOR      = -51200;
    localparam int LEVEL_CEIL       = 65535;
    localparam longint DB_PER_OCTAVE_Q16 = 197283;
    localparam int SETTLE_CYCLES    = 32;
    localparam int DRAIN_LIMIT      = 8000;

    localparam logic [wpm_pkg::PADDR_W-1:0] ADDR_WINDOW_LEN = {wpm_pkg::REG_WINDOW_LEN, 2'b00};
    localparam logic [wpm_pkg::PADDR_W-1:0] ADDR_UNMAPPED   = 3'd4;

    class power_level_tracker;
        bit [63:0]   power_mem [STORE_DEPTH];
        bit [11:0]   wr_ptr;
        int unsigned filled;
        bit [63:0]   window_total;
        bit [12:0]   win_len;
        wpm_pkg::out_word_t pending_levels [$];
        int          mismatch_count;

        function new();
            wr_ptr = '0;
            filled = 0;
            window_total = '0;
            win_len = 13'd4096;
            mismatch_count = 0;
        endfunction

        function int unsigned active_len();
            if (win_len == 0)
            begin
                return 1;
            end
            if (win_len > STORE_DEPTH)
            begin
                return STORE_DEPTH;
            end
            return 32'(win_len);
        endfunction

        function longint log2_fixed(bit [63:0] x);
            int        top;
            bit [63:0] m;
            longint    frac;
            top = 63;
            while (top > 0 && x[top] == 1'b0)
            begin
                top--;
            end
            m = (top >= 31) ? (x >> (top - 31)) : (x << (31 - top));
            frac = 0;
            repeat (16)
            begin
                m = (m * m) >> 31;
                frac = frac << 1;
                if (m >= 64'h1_0000_0000)
                begin
                    frac = frac | 1;
                    m = m >> 1;
                end
            end
            return longint'(top) * 65536 + frac;
        endfunction

        function logic signed [wpm_pkg::LEVEL_W-1:0] mean_db_q8(bit [63:0] total,
                                                                int unsigned n);
            longint    d;
            longint    p;
            longint    r;
            bit [63:0] mag;
            if (total == 0)
            begin
                return wpm_pkg::LEVEL_W'(LEVEL_FLOOR);
            end
            d = log2_fixed(total) - log2_fixed(64'(n));
            p = d * DB_PER_OCTAVE_Q16;
            mag = (p < 0) ? 64'(-p) : 64'(p);
            mag = (mag + (64'd1 << 23)) >> 24;
            r = (p < 0) ? -longint'(mag) : longint'(mag);
            if (r < LEVEL_FLOOR)
            begin
                r = LEVEL_FLOOR;
            end
            if (r > LEVEL_CEIL)
            begin
                r = LEVEL_CEIL;
            end
            return r[wpm_pkg::LEVEL_W-1:0];
        endfunction

        function void note_config(logic [wpm_pkg::PADDR_W-1:0] addr,
                                  logic [wpm_pkg::PDATA_W-1:0] value);
            if ((addr >> 2) != wpm_pkg::REG_WINDOW_LEN)
            begin
                return;
            end
            win_len = value[wpm_pkg::WLEN_W-1:0];
            filled = 0;
            window_total = '0;
        endfunction

        function void absorb_word(wpm_pkg::in_word_t w);
            int unsigned n;
            longint      si;
            longint      sq;
            bit [63:0]   pw;
            bit [11:0]   old_idx;
            wpm_pkg::out_word_t want;
            n = active_len();
            if (w.command == wpm_pkg::CMD_PUSH)
            begin
                si = longint'($signed(w.sample_i));
                sq = longint'($signed(w.sample_q));
                pw = 64'(si * si + sq * sq);
                if (filled >= n)
                begin
                    old_idx = wr_ptr - 12'(n);
                    window_total = window_total - power_mem[old_idx];
                end
                else
                begin
                    filled++;
                end
                power_mem[wr_ptr] = pw;
                window_total = window_total + pw;
                wr_ptr = wr_ptr + 12'd1;
            end
            else
            begin
                if (filled < n)
                begin
                    want.level_db_q8 = wpm_pkg::LEVEL_W'(LEVEL_FLOOR);
                    want.no_data = 1'b1;
                end
                else
                begin
                    want.level_db_q8 = mean_db_q8(window_total, n);
                    want.no_data = 1'b0;
                end
                pending_levels.push_back(want);
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatch_count++;
        endtask

        task check_level(wpm_pkg::out_word_t got);
            wpm_pkg::out_word_t want;
            if (pending_levels.size() == 0)
            begin
                report_mismatch($sformatf("unexpected level %0d no_data %0b",
                                          $signed(got.level_db_q8), got.no_data));
                return;
            end
            want = pending_levels.pop_front();
            if (got.level_db_q8 !== want.level_db_q8)
            begin
                report_mismatch($sformatf("level_db_q8 got %0d expected %0d",
                                          $signed(got.level_db_q8), $signed(want.level_db_q8)));
            end
            if (got.no_data !== want.no_data)
            begin
                report_mismatch($sformatf("no_data got %0b expected %0b",
                                          got.no_data, want.no_data));
            end
        endtask
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    wpm_pkg::in_word_t   in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    wpm_pkg::out_word_t  out_data;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [wpm_pkg::PADDR_W-1:0] paddr  = '0;
    logic [wpm_pkg::PDATA_W-1:0] pwdata = '0;
    logic [wpm_pkg::PDATA_W-1:0] prdata;
    logic                pready;

    power_level_tracker  tracker;
    bit                  calm_tx   = 1'b0;

    always #4 clk = ~clk;

    windowed_power_meter_db_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [wpm_pkg::SAMPLE_BITS-1:0] rand_component(int zero_pct);
        logic signed [wpm_pkg::SAMPLE_BITS-1:0] v;
        if ($urandom_range(0, 99) < zero_pct)
        begin
            return '0;
        end
        case ($urandom_range(0, 7))
            0, 1, 2: v = wpm_pkg::SAMPLE_BITS'($urandom);
            3:
            begin
                case ($urandom_range(0, 3))
                    0: v = 16'sh8000;
                    1: v = 16'sh7FFF;
                    2: v = -16'sd1;
                    default: v = 16'sd1;
                endcase
            end
            4: v = wpm_pkg::SAMPLE_BITS'($urandom_range(0, 8)) - 16'sd4;
            default:
            begin
                v = wpm_pkg::SAMPLE_BITS'($urandom);
                v = v >>> $urandom_range(0, 15);
            end
        endcase
        return v;
    endfunction

    task automatic send_word(wpm_pkg::in_word_t w);
        int gap;
        gap = pick_gap(calm_tx);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = w;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        tracker.absorb_word(w);
        @(negedge clk);
    endtask

    task automatic send_push(logic signed [wpm_pkg::SAMPLE_BITS-1:0] si,
                             logic signed [wpm_pkg::SAMPLE_BITS-1:0] sq);
        wpm_pkg::in_word_t w;
        w.command  = wpm_pkg::CMD_PUSH;
        w.sample_i = si;
        w.sample_q = sq;
        send_word(w);
    endtask

    task automatic send_read();
        wpm_pkg::in_word_t w;
        w.command  = wpm_pkg::CMD_READ;
        w.sample_i = wpm_pkg::SAMPLE_BITS'($urandom);
        w.sample_q = wpm_pkg::SAMPLE_BITS'($urandom);
        send_word(w);
    endtask

    task automatic drain_results(int margin);
        int waited;
        waited = 0;
        in_valid = 1'b0;
        while (tracker.pending_levels.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (margin) @(negedge clk);
    endtask

    task automatic write_reg(logic [wpm_pkg::PADDR_W-1:0] addr,
                             logic [wpm_pkg::PDATA_W-1:0] value);
        drain_results(SETTLE_CYCLES);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        tracker.note_config(addr, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic run_phase(int push_target, int read_pct, int zero_pct);
        int pushed;
        pushed = 0;
        calm_tx = ($urandom_range(0, 3) == 0);
        while (pushed < push_target)
        begin
            if ($urandom_range(0, 99) < read_pct)
            begin
                send_read();
            end
            else
            begin
                send_push(rand_component(zero_pct), rand_component(zero_pct));
                pushed++;
            end
        end
        repeat (20)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                send_read();
            end
            else
            begin
                send_push(rand_component(zero_pct), rand_component(zero_pct));
            end
        end
    endtask

    initial
    begin : sink
        int  stall;
        int  calm_left;
        bit  calm_rx;
        stall = 0;
        calm_left = 0;
        calm_rx = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm_left == 0)
            begin
                calm_rx = ($urandom_range(0, 2) == 0);
                calm_left = $urandom_range(50, 400);
            end
            else
            begin
                calm_left--;
            end
            if (stall > 0)
            begin
                out_ready = 1'b0;
                stall--;
            end
            else
            begin
                out_ready = 1'b1;
                stall = pick_gap(calm_rx);
            end
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                tracker.check_level(out_data);
            end
        end
    end

    initial
    begin : watchdog
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        int win;
        tracker = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset window is the full store: every read here lacks data
        send_read();
        send_push(16'sh8000, 16'sh8000);
        send_push(16'sh7FFF, 16'sh7FFF);
        send_push(16'sh0000, 16'sh0000);
        send_push(16'sh8000, 16'sh7FFF);
        send_push(16'sd1, -16'sd1);
        send_read();

        write_reg(ADDR_WINDOW_LEN, 32'd1);
        send_push(16'sh0000, 16'sh0000);
        send_read();
        send_push(16'sh8000, 16'sh8000);
        send_read();
        send_push(16'sh7FFF, 16'sh8000);
        send_read();
        send_push(16'sd1, 16'sd0);
        send_read();

        // spare address must leave the window untouched
        write_reg(ADDR_UNMAPPED, 32'd5);
        send_read();

        write_reg(ADDR_WINDOW_LEN, 32'd0);
        send_push(16'sd3, 16'sd4);
        send_read();

        write_reg(ADDR_WINDOW_LEN, 32'd2);
        send_push(16'sh5555, 16'shAAAA);
        send_push(16'shAAAA, 16'sh5555);
        send_read();

        // oversize length clamps to the full store
        write_reg(ADDR_WINDOW_LEN, 32'd8191);
        run_phase(80, 10, 5);

        write_reg(ADDR_WINDOW_LEN, 32'd4096);
        run_phase(30, 20, 5);

        for (int p = 0; p < 10; p++)
        begin
            case (p)
                0: win = 1;
                1: win = 2;
                2: win = 0;
                3: win = $urandom_range(60, 100);
                4: win = 1;
                default: win = $urandom_range(1, 32);
            endcase
            write_reg(ADDR_WINDOW_LEN, wpm_pkg::PDATA_W'(win));
            run_phase(((win == 0) ? 1 : win) * 2 + $urandom_range(10, 30), 25,
                      (p == 4) ? 80 : $urandom_range(0, 15));
        end

        drain_results(SETTLE_CYCLES);
        if (tracker.pending_levels.size() != 0)
        begin
            tracker.report_mismatch($sformatf("%0d levels never arrived",
                                              tracker.pending_levels.size()));
        end
        if (tracker.mismatch_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
